// ===== design/kmp_substring_search_defines.svh =====
// ----------------------------------------------------------------------------
// kmp substring search assertion macros
// shared property forms, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_SEARCH_DEFINES_SVH
`define KMP_SUBSTRING_SEARCH_DEFINES_SVH

// condition holds at every edge out of reset
`define KMP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define KMP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp package
// sizes, queue entry type and sequencer states of the substring search block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    // longest pattern kept and first text index that is no longer reported
    localparam int PAT_MAX  = 256;
    localparam int TEXT_MAX = 65536;

    localparam int BYTE_W = 8;
    localparam int MS_W   = 16;
    // pattern memory address, pattern length and signed link widths
    localparam int AW     = $clog2(PAT_MAX);
    localparam int LEN_W  = $clog2(PAT_MAX + 1);
    localparam int PTR_W  = LEN_W + 1;
    // text position saturates at TEXT_MAX + PAT_MAX
    localparam int POS_W  = $clog2(TEXT_MAX + PAT_MAX + 1);
    localparam int ST_W   = POS_W + 1;

    localparam logic [LEN_W-1:0] PAT_LIM  = LEN_W'(PAT_MAX);
    localparam logic [POS_W-1:0] POS_SAT  = POS_W'(TEXT_MAX + PAT_MAX);
    localparam logic [ST_W-1:0]  TEXT_LIM = ST_W'(TEXT_MAX);

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic              is_text;
        logic [BYTE_W-1:0] data;
        logic              last;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAT_WALK,
        ST_TXT_WALK
    } state_t;

endpackage

`default_nettype wire

// ===== design/kmp_front.sv =====
// ----------------------------------------------------------------------------
// kmp front
// takes input beats, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmp_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         mode,
    input  logic [kmp_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         last_byte,
    output logic                         q_valid,
    output kmp_pkg::item_t               q_item,
    input  logic                         q_pop
);
    import kmp_pkg::*;

    item_t            entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             push;
    logic             pop;
    item_t            new_item;

    // classify the incoming beat
    always_comb
    begin
        new_item.is_text = mode;
        new_item.data    = data_byte;
        new_item.last    = last_byte;
    end

    assign item_stall = (count_reg == QCW'(QDEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_item     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/kmp_back.sv =====
// ----------------------------------------------------------------------------
// kmp back
// pattern and failure memories, link-walking sequencer and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "kmp_substring_search_defines.svh"

module kmp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  kmp_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        found,
    output logic [kmp_pkg::MS_W-1:0]    match_start
);
    import kmp_pkg::*;

    // memories and their registered read data
    logic [BYTE_W-1:0]        pat_mem [PAT_MAX];
    logic signed [PTR_W-1:0]  fail_mem [PAT_MAX];
    logic [BYTE_W-1:0]        pat_rd_reg;
    logic signed [PTR_W-1:0]  fail_rd_reg;
    logic [AW-1:0]            rd_addr;
    logic                     pat_we;
    logic [AW-1:0]            pat_waddr;
    logic [BYTE_W-1:0]        pat_wdata;
    logic                     fail_we;
    logic [AW-1:0]            fail_waddr;
    logic signed [PTR_W-1:0]  fail_wdata;

    // sequencer and search state
    state_t                   state_reg;
    state_t                   state_next;
    logic [LEN_W-1:0]         pat_len_reg;
    logic [LEN_W-1:0]         pat_len_next;
    logic signed [PTR_W-1:0]  prefix_reg;
    logic signed [PTR_W-1:0]  prefix_next;
    logic [LEN_W-1:0]         matched_reg;
    logic [LEN_W-1:0]         matched_next;
    logic [POS_W-1:0]         text_pos_reg;
    logic [POS_W-1:0]         text_pos_next;
    logic                     done_reg;
    logic                     done_next;
    logic                     pat_closed_reg;
    logic                     pat_closed_next;
    logic                     text_ended_reg;
    logic                     text_ended_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic signed [PTR_W-1:0]  walk_reg;
    logic signed [PTR_W-1:0]  walk_next;
    logic [BYTE_W-1:0]        prev_byte_reg;
    logic [BYTE_W-1:0]        prev_byte_next;
    logic [BYTE_W-1:0]        cur_byte_reg;
    logic [BYTE_W-1:0]        cur_byte_next;
    logic                     cur_last_reg;
    logic                     cur_last_next;

    // result register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     found_reg;
    logic                     found_next;
    logic [MS_W-1:0]          start_reg;
    logic [MS_W-1:0]          start_next;

    // decode
    logic                     begin_item;
    logic [LEN_W-1:0]         pk;
    logic                     pk_room;
    logic [LEN_W-1:0]         e_matched;
    logic [POS_W-1:0]         e_pos;
    logic                     e_done;
    logic                     e_hit;
    logic                     p_neg;
    logic                     pat_stop;
    logic signed [PTR_W-1:0]  p_new;
    logic [LEN_W-1:0]         j_u;
    logic                     j_over;
    logic                     j_hit;
    logic                     f_bad;
    logic                     txt_stop;
    logic [LEN_W-1:0]         j_new;
    logic                     txt_quick;
    logic                     in_walk;
    logic                     fin_fire;
    logic [POS_W-1:0]         fin_pos;
    logic                     fin_hit;
    logic                     fin_last;
    logic                     fin_done0;
    logic                     fin_match;
    logic [ST_W-1:0]          fin_start;
    logic                     fin_report;
    logic [POS_W-1:0]         fin_pos_inc;
    logic                     emit;

    // a new item starts only when the result slot is free or draining
    assign begin_item = (state_reg == ST_IDLE) && q_valid
                        && (!out_valid_reg || !result_stall);
    assign q_pop      = begin_item;

    // search state as seen by an item, after any restart it implies
    always_comb
    begin
        pk        = pat_closed_reg ? '0 : pat_len_reg;
        pk_room   = (pk < PAT_LIM);
        e_matched = text_ended_reg ? '0 : matched_reg;
        e_pos     = text_ended_reg ? '0 : text_pos_reg;
        e_done    = text_ended_reg ? 1'b0 : done_reg;
        e_hit     = text_ended_reg ? 1'b0 : hit_reg;
    end

    // failure-table build step: stop on empty prefix or matching byte
    always_comb
    begin
        p_neg    = walk_reg[PTR_W-1];
        pat_stop = p_neg || (pat_rd_reg == prev_byte_reg);
        p_new    = p_neg ? '0 : walk_reg + PTR_W'(1);
    end

    // text step: advance on a hit, fall back through the links otherwise
    always_comb
    begin
        j_u      = walk_reg[LEN_W-1:0];
        j_over   = (j_u >= pat_len_reg);
        j_hit    = (pat_rd_reg == cur_byte_reg);
        f_bad    = fail_rd_reg[PTR_W-1] || (fail_rd_reg[LEN_W-1:0] >= j_u);
        txt_stop = j_over || j_hit || f_bad;
        j_new    = (!j_over && j_hit) ? j_u + LEN_W'(1) : '0;
    end

    // end-of-text-beat bookkeeping, shared by the quick path and the walk
    always_comb
    begin
        in_walk     = (state_reg == ST_TXT_WALK);
        txt_quick   = begin_item && q_item.is_text && (e_done || (pat_len_reg == '0));
        fin_fire    = txt_quick || (in_walk && txt_stop);
        fin_pos     = in_walk ? text_pos_reg : e_pos;
        fin_hit     = in_walk ? hit_reg : e_hit;
        fin_last    = in_walk ? cur_last_reg : q_item.last;
        fin_done0   = in_walk ? done_reg : e_done;
        fin_match   = in_walk ? (j_new == pat_len_reg) : (!e_done && (pat_len_reg == '0));
        fin_start   = (pat_len_reg == '0) ? ST_W'(fin_pos)
                    : ST_W'(fin_pos) + ST_W'(1) - ST_W'(pat_len_reg);
        fin_report  = fin_match && (fin_start < TEXT_LIM);
        fin_pos_inc = (fin_pos < POS_SAT) ? fin_pos + POS_W'(1) : fin_pos;
        emit        = fin_fire && (fin_report || (fin_last && !fin_hit));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (begin_item)
                begin
                    if (q_item.is_text)
                    begin
                        if (!e_done && (pat_len_reg != '0))
                        begin
                            state_next = ST_TXT_WALK;
                        end
                    end
                    else if (pk_room && (pk != '0))
                    begin
                        state_next = ST_PAT_WALK;
                    end
                end
            end
            ST_PAT_WALK:
            begin
                if (pat_stop)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TXT_WALK:
            begin
                if (txt_stop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        pat_len_next    = pat_len_reg;
        prefix_next     = prefix_reg;
        matched_next    = matched_reg;
        text_pos_next   = text_pos_reg;
        done_next       = done_reg;
        pat_closed_next = pat_closed_reg;
        text_ended_next = text_ended_reg;
        hit_next        = hit_reg;
        walk_next       = walk_reg;
        prev_byte_next  = prev_byte_reg;
        cur_byte_next   = cur_byte_reg;
        cur_last_next   = cur_last_reg;
        rd_addr         = '0;
        pat_we          = 1'b0;
        pat_waddr       = pk[AW-1:0];
        pat_wdata       = q_item.data;
        fail_we         = 1'b0;
        fail_waddr      = '0;
        fail_wdata      = '1;
        case (state_reg)
            ST_IDLE:
            begin
                if (begin_item && !q_item.is_text)
                begin
                    // a pattern beat after a closed pattern starts over
                    if (pat_closed_reg)
                    begin
                        pat_len_next    = '0;
                        prefix_next     = '1;
                        matched_next    = '0;
                        text_pos_next   = '0;
                        done_next       = 1'b0;
                        text_ended_next = 1'b0;
                        hit_next        = 1'b0;
                    end
                    pat_closed_next = q_item.last;
                    if (pk_room)
                    begin
                        pat_we = 1'b1;
                        if (pk == '0)
                        begin
                            fail_we        = 1'b1;
                            fail_waddr     = '0;
                            fail_wdata     = '1;
                            prefix_next    = '1;
                            pat_len_next   = LEN_W'(1);
                            prev_byte_next = q_item.data;
                        end
                        else
                        begin
                            walk_next     = prefix_reg;
                            cur_byte_next = q_item.data;
                            rd_addr       = prefix_reg[AW-1:0];
                        end
                    end
                end
                else if (begin_item)
                begin
                    pat_closed_next = 1'b1;
                    matched_next    = e_matched;
                    text_pos_next   = e_pos;
                    done_next       = e_done;
                    text_ended_next = 1'b0;
                    hit_next        = e_hit;
                    cur_byte_next   = q_item.data;
                    cur_last_next   = q_item.last;
                    walk_next       = PTR_W'(e_matched);
                    rd_addr         = e_matched[AW-1:0];
                end
            end
            ST_PAT_WALK:
            begin
                if (pat_stop)
                begin
                    fail_we        = 1'b1;
                    fail_waddr     = pat_len_reg[AW-1:0];
                    fail_wdata     = p_new;
                    prefix_next    = p_new;
                    pat_len_next   = pat_len_reg + LEN_W'(1);
                    prev_byte_next = cur_byte_reg;
                end
                else
                begin
                    walk_next = fail_rd_reg;
                    rd_addr   = fail_rd_reg[AW-1:0];
                end
            end
            ST_TXT_WALK:
            begin
                if (txt_stop)
                begin
                    matched_next = j_new;
                end
                else
                begin
                    walk_next = fail_rd_reg;
                    rd_addr   = fail_rd_reg[AW-1:0];
                end
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
        // closing a text beat
        if (fin_fire)
        begin
            done_next       = fin_done0 || fin_match;
            hit_next        = fin_hit || fin_report;
            text_pos_next   = fin_pos_inc;
            text_ended_next = fin_last;
        end
    end

    // result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            found_next     = fin_report;
            start_next     = fin_report ? MS_W'(fin_start) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pat_len_reg    <= '0;
            prefix_reg     <= '1;
            matched_reg    <= '0;
            text_pos_reg   <= '0;
            done_reg       <= 1'b0;
            pat_closed_reg <= 1'b0;
            text_ended_reg <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pat_len_reg    <= pat_len_next;
            prefix_reg     <= prefix_next;
            matched_reg    <= matched_next;
            text_pos_reg   <= text_pos_next;
            done_reg       <= done_next;
            pat_closed_reg <= pat_closed_next;
            text_ended_reg <= text_ended_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        prev_byte_reg <= prev_byte_next;
        cur_byte_reg  <= cur_byte_next;
        cur_last_reg  <= cur_last_next;
        found_reg     <= found_next;
        start_reg     <= start_next;
    end

    // pattern memory
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        pat_rd_reg <= pat_mem[rd_addr];
    end

    // failure-link memory
    always_ff @(posedge clk)
    begin
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        fail_rd_reg <= fail_mem[rd_addr];
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign match_start  = start_reg;

    // checks
    `KMP_ASSERT_IMPLY(a_no_result_overwrite, emit, !out_valid_reg || !result_stall, "result slot overwritten while stalled")
    `KMP_ASSERT_ALWAYS(a_matched_in_range, matched_reg <= pat_len_reg, "matched count beyond pattern length")
    `KMP_ASSERT_IMPLY(a_hit_means_done, hit_reg, done_reg, "match reported but search not done")
    `KMP_ASSERT_IMPLY(a_prefix_below_len, (state_reg == ST_PAT_WALK) && !walk_reg[PTR_W-1], walk_reg[LEN_W-1:0] < pat_len_reg, "prefix walk pointer past pattern end")

endmodule

`default_nettype wire

// ===== design/kmp_substring_search.sv =====
// ----------------------------------------------------------------------------
// kmp substring search
// first-occurrence pattern search over a byte stream, knuth-morris-pratt
// ----------------------------------------------------------------------------
// usage:
//   input channel item_valid / item_stall carries mode, data_byte, last_byte.
//   mode 0 loads a pattern byte, mode 1 feeds a text byte; last_byte closes
//   the pattern or the text. a pattern beat after a closed pattern starts a
//   new pattern. result channel result_valid / result_stall gives found and
//   match_start: one beat per text, on the first match or at its last byte.
//   the engine pops a beat from the input queue when it is idle. a text beat
//   then reads the pattern and link memories and follows failure links one
//   at a time, set by the single read port of those memories; it completes
//   as it is taken once the search is over or with no pattern. a pattern
//   byte also follows links, but the first or a dropped byte completes as it
//   is taken. a result is registered when its beat completes. a two-entry
//   queue keeps taking beats while the engine works or the result waits;
//   item_stall rises only when that queue is full. reset clears all search
//   state; memories need no clearing pass. a stalled result holds, and the
//   engine starts no new beat until the result slot drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmp_substring_search (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        mode,
    input  logic [kmp_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last_byte,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic                        found,
    output logic [kmp_pkg::MS_W-1:0]    match_start
);
    import kmp_pkg::*;

    logic   q_valid;
    logic   q_pop;
    item_t  q_item;

    // intake and queue
    kmp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // search engine and result slot
    kmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_start  (match_start)
    );

endmodule

`default_nettype wire
